// ----- src/ilrm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ilrm_pkg
// Shared types and constants for the indexed list remove-and-move block.
// ---------------------------------------------------------------------------
package ilrm_pkg;

	localparam int NODE_W = 11;           // node number width
	localparam int CNT_W  = 11;           // node_count register width
	localparam int CMD_W  = 2;
	localparam int PRED_W = NODE_W + 1;   // {present, pred node}

	localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_REMOVE = 2'd0;
	localparam cmd_t CMD_MOVE   = 2'd1;   // any other code queries

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_RM_LINK,
		ST_MV_PP,
		ST_MV_HEAD,
		ST_MV_SUCC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic en;
		logic we;
	} ram_ctl_t;

	typedef struct packed {
		logic [NODE_W-1:0] head;
		logic [NODE_W-1:0] pred;
		logic [NODE_W-1:0] succ;
		logic              present;
		logic              ignored;
	} result_t;

endpackage
`default_nettype wire

// ----- src/ilrm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ilrm_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ---------------------------------------------------------------------------
module ilrm_ram
	import ilrm_pkg::*;
#(
	parameter int DEPTH = 1025,
	parameter int WIDTH = 11,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire ram_ctl_t         req,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/ilrm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ilrm_ctrl
// Command sequencer: reads, patches and writes back the link tables.
// ---------------------------------------------------------------------------
module ilrm_ctrl
	import ilrm_pkg::*;
#(
	parameter int MAX_NODES = 1024,
	localparam int IDX_W    = $clog2(MAX_NODES + 1),
	localparam int CMP_W    = ((IDX_W > NODE_W) ? IDX_W : NODE_W) + 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CNT_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire cmd_t              command,
	input  wire logic [NODE_W-1:0] node_id,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output result_t                res,
	output ram_ctl_t               pred_req,
	output logic [IDX_W-1:0]       pred_addr,
	output logic [PRED_W-1:0]      pred_wdata,
	input  wire logic [PRED_W-1:0] pred_rdata,
	output ram_ctl_t               succ_req,
	output logic [IDX_W-1:0]       succ_addr,
	output logic [NODE_W-1:0]      succ_wdata,
	input  wire logic [NODE_W-1:0] succ_rdata
);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  clr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NODE_W-1:0] head_q;
	cmd_t              cmd_q;
	logic [NODE_W-1:0] id_q, p_q, s_q, pp_q;
	logic [NODE_W-1:0] rp_q, rs_q;
	logic              rpres_q, rign_q;
	result_t           res_q;
	logic              out_valid_q;

	logic              id_ok, slot_free, last_clr;
	logic [NODE_W-1:0] rd_p, rd_s;
	logic              rd_pres;
	logic [CMP_W-1:0]  n_sat, ci;
	logic              ci_in;
	logic [NODE_W-1:0] chain_pred, chain_succ;

	assign rd_p    = pred_rdata[NODE_W-1:0];
	assign rd_pres = pred_rdata[NODE_W];
	assign rd_s    = succ_rdata;

	assign id_ok = (node_id != '0) && (CMP_W'(node_id) <= CMP_W'(MAX_NODES));
	assign slot_free = !out_valid_q || out_ready;
	assign last_clr  = (clr_q == IDX_W'(MAX_NODES));

	// chain values for the rebuild sweep
	assign n_sat = (CMP_W'(cnt_q) > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : CMP_W'(cnt_q);
	assign ci    = CMP_W'(clr_q);
	assign ci_in = (ci != '0) && (ci <= n_sat);
	assign chain_pred = ci_in ? NODE_W'(ci - CMP_W'(1)) : '0;
	assign chain_succ = (ci_in && (ci < n_sat)) ? NODE_W'(ci + CMP_W'(1)) : '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (last_clr) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = id_ok ? ST_READ : ST_DONE;
			end
			ST_READ: begin
				if (!rd_pres) begin
					state_d = ST_DONE;
				end else begin
					case (cmd_q)
						CMD_REMOVE: state_d = ST_RM_LINK;
						CMD_MOVE:   state_d = (rd_p == '0) ? ST_DONE : ST_MV_PP;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_RM_LINK: state_d = ST_DONE;
			ST_MV_PP:   state_d = ST_MV_HEAD;
			ST_MV_HEAD: state_d = ST_MV_SUCC;
			ST_MV_SUCC: state_d = ST_DONE;
			ST_DONE: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
		if (cfg_wr_en) state_d = ST_CLEAR;
	end

	// memory port control
	always_comb begin
		in_ready   = 1'b0;
		pred_req   = '0;
		pred_addr  = IDX_W'(id_q);
		pred_wdata = '0;
		succ_req   = '0;
		succ_addr  = IDX_W'(id_q);
		succ_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				pred_req   = '{en: 1'b1, we: 1'b1};
				pred_addr  = clr_q;
				pred_wdata = {ci_in, chain_pred};
				succ_req   = '{en: 1'b1, we: 1'b1};
				succ_addr  = clr_q;
				succ_wdata = chain_succ;
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				pred_addr = IDX_W'(node_id);
				succ_addr = IDX_W'(node_id);
				if (in_valid && id_ok) begin
					pred_req = '{en: 1'b1, we: 1'b0};
					succ_req = '{en: 1'b1, we: 1'b0};
				end
			end
			ST_READ: begin
				if (rd_pres) begin
					case (cmd_q)
						CMD_REMOVE: begin
							pred_req = '{en: 1'b1, we: 1'b1};
							succ_req = '{en: 1'b1, we: 1'b1};
						end
						CMD_MOVE: begin
							if (rd_p != '0) begin
								// fetch pred of pred, point id forward at its pred
								pred_req   = '{en: 1'b1, we: 1'b0};
								pred_addr  = IDX_W'(rd_p);
								succ_req   = '{en: 1'b1, we: 1'b1};
								succ_wdata = rd_p;
							end
						end
						default: ;
					endcase
				end
			end
			ST_RM_LINK: begin
				if (p_q != '0) begin
					succ_req   = '{en: 1'b1, we: 1'b1};
					succ_addr  = IDX_W'(p_q);
					succ_wdata = s_q;
				end
				if (s_q != '0) begin
					pred_req   = '{en: 1'b1, we: 1'b1};
					pred_addr  = IDX_W'(s_q);
					pred_wdata = {1'b1, p_q};
				end
			end
			ST_MV_PP: begin
				pred_req   = '{en: 1'b1, we: 1'b1};
				pred_wdata = {1'b1, rd_p};
				succ_req   = '{en: 1'b1, we: 1'b1};
				succ_addr  = IDX_W'(p_q);
				succ_wdata = s_q;
			end
			ST_MV_HEAD: begin
				pred_req   = '{en: 1'b1, we: 1'b1};
				pred_addr  = IDX_W'(p_q);
				pred_wdata = {1'b1, id_q};
				if (pp_q != '0) begin
					succ_req   = '{en: 1'b1, we: 1'b1};
					succ_addr  = IDX_W'(pp_q);
					succ_wdata = id_q;
				end
			end
			ST_MV_SUCC: begin
				if (s_q != '0) begin
					pred_req   = '{en: 1'b1, we: 1'b1};
					pred_addr  = IDX_W'(s_q);
					pred_wdata = {1'b1, p_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= NODE_COUNT_RST;
			head_q      <= NODE_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				cnt_q  <= cfg_wr_data;
				head_q <= (cfg_wr_data != '0) ? NODE_W'(1) : '0;
				clr_q  <= '0;
			end else begin
				if (state_q == ST_CLEAR) clr_q <= clr_q + IDX_W'(1);
				if (state_q == ST_READ && rd_pres && cmd_q == CMD_REMOVE && rd_p == '0) begin
					head_q <= rd_s;
				end
				if (state_q == ST_MV_PP && rd_p == '0) head_q <= id_q;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q   <= command;
				id_q    <= node_id;
				rign_q  <= !id_ok;
				rp_q    <= '0;
				rs_q    <= '0;
				rpres_q <= 1'b0;
			end
			ST_READ: begin
				p_q <= rd_p;
				s_q <= rd_s;
				if (!rd_pres) begin
					rign_q <= 1'b1;
				end else begin
					case (cmd_q)
						CMD_REMOVE: rpres_q <= 1'b0;
						CMD_MOVE: begin
							rpres_q <= 1'b1;
							rs_q    <= rd_s;
						end
						default: begin
							rpres_q <= 1'b1;
							rp_q    <= rd_p;
							rs_q    <= rd_s;
						end
					endcase
				end
			end
			ST_MV_PP: begin
				pp_q <= rd_p;
				rp_q <= rd_p;
				rs_q <= p_q;
			end
			ST_DONE: begin
				if (slot_free) res_q <= '{head: head_q, pred: rp_q, succ: rs_q,
					present: rpres_q, ignored: rign_q};
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

// ----- src/indexed_list_remove_and_move_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// indexed_list_remove_and_move_top
// Ordered list of numbered nodes kept as predecessor and successor tables.
// Commands remove a node, move it one place forward, or query it.
// ---------------------------------------------------------------------------
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   in       | in_valid / in_ready   | command, node_id
//   out      | out_valid / out_ready | head_node, pred_node, succ_node,
//            |                       | node_present, cmd_ignored
//   cfg      | cfg_wr_en             | cfg_wr_data (node_count)
//
// One command at a time. An out-of-range id goes straight to the result, a
// query or absent node only reads both tables, a remove then patches the
// neighbours' links, and a move patches them in the MV_PP, MV_HEAD and MV_SUCC
// write states (none when the node is already the head); the steps are set
// by the single port of each table RAM (one read or write a cycle). Reset and
// every node_count write run a rebuild sweep over all MAX_NODES+1 table entries
// with in_ready low. A held result only stalls the finishing transaction; the
// next transaction is already taken while the output register waits.
module indexed_list_remove_and_move_top
	import ilrm_pkg::*;
#(
	parameter int MAX_NODES = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_wr_en,
	input  wire logic [CNT_W-1:0]  cfg_wr_data,
	// command channel
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [NODE_W-1:0] node_id,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [NODE_W-1:0]      head_node,
	output logic [NODE_W-1:0]      pred_node,
	output logic [NODE_W-1:0]      succ_node,
	output logic                   node_present,
	output logic                   cmd_ignored
);

	localparam int DEPTH = MAX_NODES + 1;       // entry 0 unused, ids from 1
	localparam int IDX_W = $clog2(DEPTH);

	ram_ctl_t          pred_req, succ_req;
	logic [IDX_W-1:0]  pred_addr, succ_addr;
	logic [PRED_W-1:0] pred_wdata, pred_rdata;
	logic [NODE_W-1:0] succ_wdata, succ_rdata;
	result_t           res;

	ilrm_ctrl #(
		.MAX_NODES (MAX_NODES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.node_id     (node_id),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.res         (res),
		.pred_req    (pred_req),
		.pred_addr   (pred_addr),
		.pred_wdata  (pred_wdata),
		.pred_rdata  (pred_rdata),
		.succ_req    (succ_req),
		.succ_addr   (succ_addr),
		.succ_wdata  (succ_wdata),
		.succ_rdata  (succ_rdata)
	);

	// predecessor table, with the present bit in the top of each word
	ilrm_ram #(
		.DEPTH (DEPTH),
		.WIDTH (PRED_W)
	) u_pred_ram (
		.clk   (clk),
		.req   (pred_req),
		.addr  (pred_addr),
		.wdata (pred_wdata),
		.rdata (pred_rdata)
	);

	// successor table
	ilrm_ram #(
		.DEPTH (DEPTH),
		.WIDTH (NODE_W)
	) u_succ_ram (
		.clk   (clk),
		.req   (succ_req),
		.addr  (succ_addr),
		.wdata (succ_wdata),
		.rdata (succ_rdata)
	);

	assign head_node    = res.head;
	assign pred_node    = res.pred;
	assign succ_node    = res.succ;
	assign node_present = res.present;
	assign cmd_ignored  = res.ignored;

endmodule
`default_nettype wire

// ----- src/ilrm_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ilrm_chk
// Port-level checks for the indexed list block, bound to the top level.
// ---------------------------------------------------------------------------
module ilrm_chk
	import ilrm_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cfg_wr_en,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [NODE_W-1:0] head_node,
	input wire logic [NODE_W-1:0] pred_node,
	input wire logic [NODE_W-1:0] succ_node,
	input wire logic              node_present,
	input wire logic              cmd_ignored
);

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(head_node) &&
		$stable(pred_node) && $stable(succ_node) && $stable(node_present) &&
		$stable(cmd_ignored))
		else $error("result changed while stalled");

	// one command in flight
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command taken while busy");

	// a count write starts the rebuild
	a_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> !in_ready)
		else $error("command taken during rebuild");

	// no links reported for a node out of the list
	a_no_links: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (cmd_ignored || !node_present) |-> pred_node == '0 && succ_node == '0)
		else $error("links reported for absent node");

	a_ign_absent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmd_ignored |-> !node_present)
		else $error("ignored command reports present node");

endmodule

bind indexed_list_remove_and_move_top ilrm_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_wr_en    (cfg_wr_en),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.head_node    (head_node),
	.pred_node    (pred_node),
	.succ_node    (succ_node),
	.node_present (node_present),
	.cmd_ignored  (cmd_ignored)
);
`default_nettype wire
